/* sv/uvs_pkg.sv */
// Shared types, constants and the CORDIC arctangent table of the UV-sphere vertex generator.
`default_nettype none

package uvs_pkg;

    localparam int DEF_SEGMENT_BITS  = 10;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam int DIV_STEPS = 33;
    localparam int QUO_W     = 34;
    localparam int CW        = 34;
    localparam int ZW        = 32;
    localparam int TEX_W     = 17;
    localparam int POS_W     = 17;
    localparam int NORM_W    = 16;
    localparam int RADIUS_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_CNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LON_CNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 16'd256;
    localparam int                  LAT_CNT_RESET = 16;
    localparam int                  LON_CNT_RESET = 32;

    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;

    typedef struct packed {
        logic               valid;
        logic               oog;
        logic [TEX_W-1:0]   tex_u;
        logic [TEX_W-1:0]   tex_v;
    } tag_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [ZW-1:0] z;
        logic [1:0]    quad;
    } rot_t;

    function automatic logic [31:0] cordic_atan(input int unsigned idx);
        logic [31:0] a;
        unique case (idx)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* sv/uvs_div_cell.sv */
// One restoring-division cell: produces one quotient bit per clock in which en is high.
`default_nettype none

module uvs_div_cell
    import uvs_pkg::*;
#(
    parameter int SEGMENT_BITS = DEF_SEGMENT_BITS
)(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [SEGMENT_BITS-1:0] den,
    input  wire logic [SEGMENT_BITS-1:0] rem_in,
    input  wire logic [QUO_W-1:0]        quo_in,
    output logic      [SEGMENT_BITS-1:0] rem_out,
    output logic      [QUO_W-1:0]        quo_out
);

    logic [SEGMENT_BITS:0]   rem2;
    logic [SEGMENT_BITS:0]   diff;
    logic                    qbit;
    logic [SEGMENT_BITS-1:0] rem_next;

    always_comb
    begin
        rem2     = {rem_in, 1'b0};
        diff     = rem2 - {1'b0, den};
        qbit     = (rem2 >= {1'b0, den});
        rem_next = qbit ? diff[SEGMENT_BITS-1:0] : rem2[SEGMENT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= rem_next;
            quo_out <= {quo_in[QUO_W-2:0], qbit};
        end
    end

endmodule

`default_nettype wire

/* sv/uvs_cordic_cell.sv */
// One CORDIC rotation cell with a fixed shift and arctangent.
`default_nettype none

module uvs_cordic_cell
    import uvs_pkg::*;
#(
    parameter int STAGE = 0
)(
    input  wire logic clk,
    input  wire logic en,
    input  wire rot_t rot_in,
    output rot_t      rot_out
);

    localparam logic [ZW-1:0] ATAN = cordic_atan(STAGE);

    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] z;
    rot_t                 rot_next;

    always_comb
    begin
        x  = $signed(rot_in.x);
        y  = $signed(rot_in.y);
        z  = $signed(rot_in.z);
        xs = x >>> STAGE;
        ys = y >>> STAGE;
        rot_next.quad = rot_in.quad;
        if (!z[ZW-1])
        begin
            rot_next.x = x - ys;
            rot_next.y = y + xs;
            rot_next.z = z - $signed(ATAN);
        end
        else
        begin
            rot_next.x = x + ys;
            rot_next.y = y - xs;
            rot_next.z = z + $signed(ATAN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_out <= rot_next;
        end
    end

endmodule

`default_nettype wire

/* sv/uv_sphere_vertex_generator.sv */
// Top level of the UV-sphere vertex generator: divider chain, CORDIC chains, vertex math.
//
// Takes one grid point (lat_step, lon_step) per clock while the pipeline advances and returns
// one vertex word per point, in order. The pipeline is made up of the input
// register, the two 33-cell divider chains (one quotient bit per cell), the angle register,
// the two CORDIC chains (one rotation per cell) and five stages of quadrant mapping, two
// multiplies, rounding and saturation.
// The whole pipeline advances while the output word is empty or being taken; a stalled
// output word holds the pipeline and input. Configuration is taken at any cycle but is read
// along the whole pipeline; write it only while the block is idle.
`default_nettype none

module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int SEGMENT_BITS  = DEF_SEGMENT_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [RADIUS_W-1:0]           cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [SEGMENT_BITS-1:0]       lat_step,
    input  wire logic [SEGMENT_BITS-1:0]       lon_step,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [POS_W-1:0]            pos_x,
    output logic signed [POS_W-1:0]            pos_y,
    output logic signed [POS_W-1:0]            pos_z,
    output logic signed [NORM_W-1:0]           norm_x,
    output logic signed [NORM_W-1:0]           norm_y,
    output logic signed [NORM_W-1:0]           norm_z,
    output logic [TEX_W-1:0]                   tex_u,
    output logic [TEX_W-1:0]                   tex_v,
    output logic                               out_of_grid
);

    localparam int ST_A   = DIV_STEPS + 1;
    localparam int ST_Q   = ST_A + CORDIC_STAGES + 1;
    localparam int ST_M1  = ST_Q + 1;
    localparam int ST_R   = ST_M1 + 1;
    localparam int ST_M2  = ST_R + 1;
    localparam int ST_O   = ST_M2 + 1;
    localparam int NST    = ST_O + 1;
    localparam int PW     = 2 * 32;
    localparam int RPW    = 32 + RADIUS_W + 1;

    localparam logic signed [RPW-1:0]    POS_MAX  = RPW'(65535);
    localparam logic signed [RPW-1:0]    POS_MIN  = -RPW'(65535);
    localparam logic signed [31:0]       NORM_MAX = 32'sd16384;
    localparam logic signed [31:0]       NORM_MIN = -32'sd16384;

    // configuration
    logic [RADIUS_W-1:0]     radius_reg;
    logic [SEGMENT_BITS-1:0] lat_cnt_reg;
    logic [SEGMENT_BITS-1:0] lon_cnt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_RESET;
            lat_cnt_reg <= SEGMENT_BITS'(LAT_CNT_RESET);
            lon_cnt_reg <= SEGMENT_BITS'(LON_CNT_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data;
                REG_LAT_CNT: lat_cnt_reg <= cfg_data[SEGMENT_BITS-1:0];
                REG_LON_CNT: lon_cnt_reg <= cfg_data[SEGMENT_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // pipeline advance
    tag_t tag_reg [NST];
    logic adv;

    assign adv      = !tag_reg[ST_O].valid || out_ready;
    assign in_ready = adv;

    // divider chains
    logic [SEGMENT_BITS-1:0] lat_rem [DIV_STEPS+1];
    logic [QUO_W-1:0]        lat_quo [DIV_STEPS+1];
    logic [SEGMENT_BITS-1:0] lon_rem [DIV_STEPS+1];
    logic [QUO_W-1:0]        lon_quo [DIV_STEPS+1];

    logic in_oog;
    logic lat_full;
    logic lon_full;

    always_comb
    begin
        in_oog   = (lat_cnt_reg == '0) || (lon_cnt_reg == '0) ||
                   (lat_step > lat_cnt_reg) || (lon_step > lon_cnt_reg);
        lat_full = (lat_step == lat_cnt_reg);
        lon_full = (lon_step == lon_cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat_rem[0] <= lat_full ? '0 : lat_step;
            lat_quo[0] <= QUO_W'(lat_full);
            lon_rem[0] <= lon_full ? '0 : lon_step;
            lon_quo[0] <= QUO_W'(lon_full);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++)
        begin : g_div
            uvs_div_cell #(.SEGMENT_BITS(SEGMENT_BITS)) u_lat (
                .clk     (clk),
                .en      (adv),
                .den     (lat_cnt_reg),
                .rem_in  (lat_rem[g]),
                .quo_in  (lat_quo[g]),
                .rem_out (lat_rem[g+1]),
                .quo_out (lat_quo[g+1])
            );
            uvs_div_cell #(.SEGMENT_BITS(SEGMENT_BITS)) u_lon (
                .clk     (clk),
                .en      (adv),
                .den     (lon_cnt_reg),
                .rem_in  (lon_rem[g]),
                .quo_in  (lon_quo[g]),
                .rem_out (lon_rem[g+1]),
                .quo_out (lon_quo[g+1])
            );
        end
    endgenerate

    // angles and texture coordinates
    logic [QUO_W-1:0]   lat_q;
    logic [QUO_W-1:0]   lon_q;
    logic [QUO_W-1:0]   theta_sum;
    logic [QUO_W:0]     phi_sum;
    logic [31:0]        theta;
    logic [31:0]        phi;
    logic [TEX_W+1:0]   u_sum;
    logic [TEX_W+1:0]   v_sum;

    always_comb
    begin
        lat_q     = lat_quo[DIV_STEPS];
        lon_q     = lon_quo[DIV_STEPS];
        theta_sum = {1'b0, lat_q[QUO_W-1:1]} + QUO_W'(1);
        phi_sum   = {1'b0, lon_q} + (QUO_W+1)'(1);
        theta     = theta_sum[32:1];
        phi       = phi_sum[32:1];
        u_sum     = {1'b0, lon_q[QUO_W-1:16]} + (TEX_W+2)'(1);
        v_sum     = {1'b0, lat_q[QUO_W-1:16]} + (TEX_W+2)'(1);
    end

    // tag line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (i == 0)
                begin
                    tag_reg[i] <= '{valid: in_valid, oog: in_oog, tex_u: '0, tex_v: '0};
                end
                else if (i == ST_A)
                begin
                    tag_reg[i].valid <= tag_reg[i-1].valid;
                    tag_reg[i].oog   <= tag_reg[i-1].oog;
                    tag_reg[i].tex_u <= u_sum[TEX_W:1];
                    tag_reg[i].tex_v <= v_sum[TEX_W:1];
                end
                else
                begin
                    tag_reg[i] <= tag_reg[i-1];
                end
            end
        end
    end

    // CORDIC chains
    rot_t rt [CORDIC_STAGES+1];
    rot_t rp [CORDIC_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt[0] <= '{x: GAIN_INV, y: '0, z: {2'b00, theta[29:0]}, quad: theta[31:30]};
            rp[0] <= '{x: GAIN_INV, y: '0, z: {2'b00, phi[29:0]},   quad: phi[31:30]};
        end
    end

    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cordic
            uvs_cordic_cell #(.STAGE(g)) u_theta (
                .clk     (clk),
                .en      (adv),
                .rot_in  (rt[g]),
                .rot_out (rt[g+1])
            );
            uvs_cordic_cell #(.STAGE(g)) u_phi (
                .clk     (clk),
                .en      (adv),
                .rot_in  (rp[g]),
                .rot_out (rp[g+1])
            );
        end
    endgenerate

    // quadrant mapping
    logic signed [31:0] st_reg, ct_reg, sp_reg, cp_reg;
    logic [CW-1:0]      st_next, ct_next, sp_next, cp_next;

    always_comb
    begin
        case (rt[CORDIC_STAGES].quad)
            2'd0:    begin ct_next = rt[CORDIC_STAGES].x;  st_next = rt[CORDIC_STAGES].y;  end
            2'd1:    begin ct_next = -rt[CORDIC_STAGES].y; st_next = rt[CORDIC_STAGES].x;  end
            2'd2:    begin ct_next = -rt[CORDIC_STAGES].x; st_next = -rt[CORDIC_STAGES].y; end
            default: begin ct_next = rt[CORDIC_STAGES].y;  st_next = -rt[CORDIC_STAGES].x; end
        endcase
        case (rp[CORDIC_STAGES].quad)
            2'd0:    begin cp_next = rp[CORDIC_STAGES].x;  sp_next = rp[CORDIC_STAGES].y;  end
            2'd1:    begin cp_next = -rp[CORDIC_STAGES].y; sp_next = rp[CORDIC_STAGES].x;  end
            2'd2:    begin cp_next = -rp[CORDIC_STAGES].x; sp_next = -rp[CORDIC_STAGES].y; end
            default: begin cp_next = rp[CORDIC_STAGES].y;  sp_next = -rp[CORDIC_STAGES].x; end
        endcase
    end

    // products, rounding, radius scaling
    logic signed [PW-1:0]  px_reg, pz_reg;
    logic signed [31:0]    cty_reg;
    logic signed [PW-1:0]  px_rnd, pz_rnd;
    logic signed [31:0]    rx_reg, ry_reg, rz_reg;
    logic signed [31:0]    nx_reg, ny_reg, nz_reg;
    logic signed [RPW-1:0] qx_reg, qy_reg, qz_reg;
    logic signed [RADIUS_W:0] rad_s;

    always_comb
    begin
        px_rnd = (px_reg + (PW'(1) <<< 29)) >>> 30;
        pz_rnd = (pz_reg + (PW'(1) <<< 29)) >>> 30;
        rad_s  = $signed({1'b0, radius_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg  <= $signed(st_next[31:0]);
            ct_reg  <= $signed(ct_next[31:0]);
            sp_reg  <= $signed(sp_next[31:0]);
            cp_reg  <= $signed(cp_next[31:0]);
            px_reg  <= st_reg * cp_reg;
            pz_reg  <= st_reg * sp_reg;
            cty_reg <= ct_reg;
            rx_reg  <= px_rnd[31:0];
            ry_reg  <= cty_reg;
            rz_reg  <= pz_rnd[31:0];
            qx_reg  <= RPW'(rad_s) * RPW'(rx_reg);
            qy_reg  <= RPW'(rad_s) * RPW'(ry_reg);
            qz_reg  <= RPW'(rad_s) * RPW'(rz_reg);
            nx_reg  <= rx_reg;
            ny_reg  <= ry_reg;
            nz_reg  <= rz_reg;
        end
    end

    // output word
    logic signed [RPW-1:0] qx_r, qy_r, qz_r;
    logic signed [31:0]    nx_r, ny_r, nz_r;
    logic signed [POS_W-1:0]  pos_x_next, pos_y_next, pos_z_next;
    logic signed [NORM_W-1:0] norm_x_next, norm_y_next, norm_z_next;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RPW-1:0] v);
        logic signed [RPW-1:0] c;
        c = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
        return c[POS_W-1:0];
    endfunction

    function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [31:0] v);
        logic signed [31:0] c;
        c = (v > NORM_MAX) ? NORM_MAX : ((v < NORM_MIN) ? NORM_MIN : v);
        return c[NORM_W-1:0];
    endfunction

    always_comb
    begin
        qx_r = (qx_reg + (RPW'(1) <<< 29)) >>> 30;
        qy_r = (qy_reg + (RPW'(1) <<< 29)) >>> 30;
        qz_r = (qz_reg + (RPW'(1) <<< 29)) >>> 30;
        nx_r = (nx_reg + 32'sd32768) >>> 16;
        ny_r = (ny_reg + 32'sd32768) >>> 16;
        nz_r = (nz_reg + 32'sd32768) >>> 16;
        if (tag_reg[ST_M2].oog)
        begin
            pos_x_next  = '0;
            pos_y_next  = '0;
            pos_z_next  = '0;
            norm_x_next = '0;
            norm_y_next = '0;
            norm_z_next = '0;
        end
        else
        begin
            pos_x_next  = sat_pos(qx_r);
            pos_y_next  = sat_pos(qy_r);
            pos_z_next  = sat_pos(qz_r);
            norm_x_next = sat_norm(nx_r);
            norm_y_next = sat_norm(ny_r);
            norm_z_next = sat_norm(nz_r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x  <= pos_x_next;
            pos_y  <= pos_y_next;
            pos_z  <= pos_z_next;
            norm_x <= norm_x_next;
            norm_y <= norm_y_next;
            norm_z <= norm_z_next;
        end
    end

    assign out_valid   = tag_reg[ST_O].valid;
    assign out_of_grid = tag_reg[ST_O].oog;
    assign tex_u       = tag_reg[ST_O].oog ? '0 : tag_reg[ST_O].tex_u;
    assign tex_v       = tag_reg[ST_O].oog ? '0 : tag_reg[ST_O].tex_v;

endmodule

`default_nettype wire
